/* rtl/tap_impact_detector_assert.svh */
// Assertion macros for the tap impact detector.
// Included by the RTL files that carry concurrent checks; ASSERT_OFF removes them.
`ifndef TAP_IMPACT_DETECTOR_ASSERT_SVH
`define TAP_IMPACT_DETECTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define TID_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tap impact detector check failed");
`define TID_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tap impact detector reset check failed");
`else
`define TID_ASSERT(label, clk, rst, prop)
`define TID_ASSERT_RST(label, clk, prop)
`endif
`endif

/* rtl/tid_pkg.sv */
// Shared constants and types of the tap impact detector.
// No dependencies; used by tid_lane, tid_norm and tap_impact_detector.
package tid_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 48;

  localparam int LIN_W  = SAMPLE_BITS + 1;   // gravity-removed value
  localparam int MAG_W  = SAMPLE_BITS;       // magnitude of a lane operand
  localparam int GRAV_W = SAMPLE_BITS + 9;   // gravity estimate, sample times 256
  localparam int SQ_W   = 2 * SAMPLE_BITS;   // square of a linear component
  localparam int INT_W  = 64;                // integrals
  localparam int DIR_W  = 16;                // normalized outputs
  localparam int T_LO   = TIME_BITS / 2;     // low half of elapsed time
  localparam int T_HI   = TIME_BITS - T_LO;

  // config register indexes
  localparam logic [1:0] REG_WEIGHT  = 2'd0;
  localparam logic [1:0] REG_THRESH  = 2'd1;
  localparam logic [1:0] REG_HOLDOFF = 2'd2;

  // per-step strobes from the sequencer to the axis lanes
  typedef struct packed {
    logic grav_en;   // update gravity estimate
    logic lin_en;    // form linear value and operand
    logic mul_lo;    // low partial product, square
    logic mul_hi;    // high partial product
    logic acc_en;    // saturating accumulate
    logic gyro;      // item is a gyroscope sample
    logic clear;     // clear both integrals
  } lane_ctrl_t;

endpackage

/* rtl/tid_lane.sv */
// One axis lane: gravity average, linear value, elapsed-time product and integrals.
// Depends on tid_pkg.
module tid_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tid_pkg::lane_ctrl_t                    ctrl,
  input  logic [8:0]                             weight,
  input  logic signed [tid_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [tid_pkg::TIME_BITS-1:0]          dt,
  output logic signed [tid_pkg::LIN_W-1:0]       lin,
  output logic [tid_pkg::SQ_W-1:0]               lin_sq,
  output logic signed [tid_pkg::INT_W-1:0]       accel_int,
  output logic signed [tid_pkg::INT_W-1:0]       rate_int
);

  localparam int MW = tid_pkg::GRAV_W + 10;
  localparam int PW = tid_pkg::MAG_W + tid_pkg::TIME_BITS;
  localparam int LW = tid_pkg::MAG_W + tid_pkg::T_LO;
  localparam int HW = tid_pkg::MAG_W + tid_pkg::T_HI;

  logic signed [tid_pkg::GRAV_W-1:0] gravity;
  logic [tid_pkg::MAG_W-1:0]         val_mag;
  logic                              val_neg;
  logic [LW-1:0]                     plo;
  logic [HW-1:0]                     phi;

  logic [8:0]                        wn;
  logic signed [MW-1:0]              prod_old, prod_new;
  logic signed [tid_pkg::SAMPLE_BITS+9:0] prod_s;
  logic signed [MW:0]                gsum;
  logic signed [tid_pkg::LIN_W-1:0]  lin_calc, op_val;
  logic [PW-1:0]                     pmag;
  logic                              p_big;
  logic signed [tid_pkg::INT_W-1:0]  term, base;
  logic signed [tid_pkg::INT_W:0]    sum;
  logic signed [tid_pkg::INT_W-1:0]  sat_sum;
  logic signed [2*tid_pkg::LIN_W-1:0] sq_full;

  // gravity average: floor((w*g + (256-w)*s*256) / 256)
  always_comb begin
    wn       = 9'd256 - weight;
    prod_old = MW'($signed({1'b0, weight}) * gravity);
    prod_s   = $signed({1'b0, wn}) * sample;
    prod_new = MW'(prod_s) <<< 8;
    gsum     = (MW+1)'(prod_old) + (MW+1)'(prod_new);
  end

  // linear value and multiplier operand
  always_comb begin
    lin_calc = tid_pkg::LIN_W'(sample) - gravity[tid_pkg::GRAV_W-1:8];
    op_val   = ctrl.gyro ? tid_pkg::LIN_W'(sample) : lin_calc;
  end

  // product magnitude, saturated to the signed 64-bit range
  always_comb begin
    pmag  = (PW'(phi) << tid_pkg::T_LO) + PW'(plo);
    p_big = 128'(pmag) > 128'(64'h7FFF_FFFF_FFFF_FFFF);
    if (p_big) begin
      term = val_neg ? $signed(64'h8000_0000_0000_0000) : $signed(64'h7FFF_FFFF_FFFF_FFFF);
    end else begin
      term = val_neg ? -$signed(64'(pmag)) : $signed(64'(pmag));
    end
    base = ctrl.gyro ? rate_int : accel_int;
    sum  = (tid_pkg::INT_W+1)'(base) + (tid_pkg::INT_W+1)'(term);
    if (sum[tid_pkg::INT_W] != sum[tid_pkg::INT_W-1]) begin
      sat_sum = sum[tid_pkg::INT_W] ? $signed(64'h8000_0000_0000_0000)
                                    : $signed(64'h7FFF_FFFF_FFFF_FFFF);
    end else begin
      sat_sum = sum[tid_pkg::INT_W-1:0];
    end
    sq_full = lin * lin;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity   <= '0;
      accel_int <= '0;
      rate_int  <= '0;
    end else begin
      if (ctrl.grav_en && !ctrl.gyro) begin
        gravity <= tid_pkg::GRAV_W'(gsum >>> 8);
      end
      if (ctrl.clear) begin
        accel_int <= '0;
        rate_int  <= '0;
      end else if (ctrl.acc_en) begin
        if (ctrl.gyro) begin
          rate_int <= sat_sum;
        end else begin
          accel_int <= sat_sum;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.lin_en) begin
      if (!ctrl.gyro) begin
        lin <= lin_calc;
      end
      val_neg <= op_val[tid_pkg::LIN_W-1];
      val_mag <= tid_pkg::MAG_W'(op_val[tid_pkg::LIN_W-1] ? -op_val : op_val);
    end
    if (ctrl.mul_lo) begin
      plo    <= val_mag * dt[tid_pkg::T_LO-1:0];
      lin_sq <= sq_full[tid_pkg::SQ_W-1:0];
    end
    if (ctrl.mul_hi) begin
      phi <= val_mag * dt[tid_pkg::TIME_BITS-1:tid_pkg::T_LO];
    end
  end

endmodule

/* rtl/tid_norm.sv */
// Vector normalization to Q1.14: shift search, iterative square root, three dividers.
// Depends on tid_pkg and tap_impact_detector_assert.svh.
`include "tap_impact_detector_assert.svh"
module tid_norm (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [tid_pkg::INT_W-1:0] vec [3],
  output logic                             busy,
  output logic signed [tid_pkg::DIR_W-1:0] dir [3]
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_PREP  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]  state;
  logic [63:0] mag [3];
  logic [2:0]  neg;
  logic [1:0]  sq_idx;
  logic [4:0]  cnt;
  logic [63:0] acc, rx, root, bit_r;
  logic [31:0] rem [3];
  logic [14:0] nbits [3];
  logic [14:0] quo [3];

  logic        any_wide;
  logic [61:0] sq_prod;
  logic [63:0] trial;
  logic [32:0] r2 [3];
  logic [2:0]  ge;

  always_comb begin
    any_wide = (mag[0][63:31] != '0) || (mag[1][63:31] != '0) || (mag[2][63:31] != '0);
    sq_prod  = mag[sq_idx][30:0] * mag[sq_idx][30:0];
    trial    = root + bit_r;
    for (int i = 0; i < 3; i++) begin
      r2[i] = {rem[i], nbits[i][14]};
      ge[i] = r2[i] >= {1'b0, root[31:0]};
      dir[i] = neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    end
  end

  assign busy = (state != N_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE:  if (start) state <= N_SHIFT;
        N_SHIFT: if (!any_wide) state <= N_SQ;
        N_SQ:    if (sq_idx == 2'd2) state <= N_SQRT;
        N_SQRT:  if (cnt == 5'd31) state <= N_PREP;
        N_PREP:  state <= (root == '0) ? N_IDLE : N_DIV;
        N_DIV:   if (cnt == 5'd14) state <= N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i][63];
            mag[i] <= vec[i][63] ? 64'(0) - 64'(vec[i]) : 64'(vec[i]);
          end
        end
      end
      N_SHIFT: begin
        if (any_wide) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end
        sq_idx <= '0;
        acc    <= '0;
      end
      N_SQ: begin
        sq_idx <= sq_idx + 2'd1;
        acc    <= acc + 64'(sq_prod);
        rx     <= acc + 64'(sq_prod);
        root   <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        cnt    <= '0;
      end
      N_SQRT: begin
        // one result bit per cycle
        if (rx >= trial) begin
          rx   <= rx - trial;
          root <= (root >> 1) + bit_r;
        end else begin
          root <= root >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt   <= cnt + 5'd1;
      end
      N_PREP: begin
        cnt <= '0;
        for (int i = 0; i < 3; i++) begin
          quo[i]   <= '0;
          rem[i]   <= 32'(mag[i][30:1]);
          nbits[i] <= {mag[i][0], 14'd0};
        end
      end
      N_DIV: begin
        // restoring division, one quotient bit per cycle in each lane
        cnt <= cnt + 5'd1;
        for (int i = 0; i < 3; i++) begin
          rem[i]   <= ge[i] ? 32'(r2[i] - {1'b0, root[31:0]}) : r2[i][31:0];
          quo[i]   <= {quo[i][13:0], ge[i]};
          nbits[i] <= nbits[i] << 1;
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  `TID_ASSERT(a_start_idle, clk, rst, start |-> state == N_IDLE)
  `TID_ASSERT(a_sq_narrow, clk, rst, state == N_SQ |-> !any_wide)
  `TID_ASSERT(a_div_nonzero, clk, rst, state == N_DIV |-> root != '0)

endmodule

/* rtl/tap_impact_detector.sv */
// Tap impact detector top level: three axis lanes, threshold merge, two normalizers.
// An item runs S_GRAV to S_ACC before ready returns; accelerometer items also S_CHK.
// A reported impact then runs the normalizers: shift search, 3 squares, 32 root steps,
// 1 setup, 15 divide steps (skipped for a zero root).
// The result is loaded as ready returns; a result still held stalls the next impact.
// Sync active-high reset clears control state, gravity, integrals; restores cfg defaults.
`include "tap_impact_detector_assert.svh"
module tap_impact_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   op,
  input  logic [tid_pkg::TIME_BITS-1:0]          timestamp,
  input  logic signed [tid_pkg::SAMPLE_BITS-1:0] sample_x,
  input  logic signed [tid_pkg::SAMPLE_BITS-1:0] sample_y,
  input  logic signed [tid_pkg::SAMPLE_BITS-1:0] sample_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [47:0]                            impact_time,
  output logic signed [16:0]                     linear_x,
  output logic signed [16:0]                     linear_y,
  output logic signed [16:0]                     linear_z,
  output logic signed [15:0]                     accel_dir_x,
  output logic signed [15:0]                     accel_dir_y,
  output logic signed [15:0]                     accel_dir_z,
  output logic signed [15:0]                     rot_dir_x,
  output logic signed [15:0]                     rot_dir_y,
  output logic signed [15:0]                     rot_dir_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [1:0]                             cfg_index,
  input  logic [31:0]                            cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRAV = 3'd1;
  localparam logic [2:0] S_LIN  = 3'd2;
  localparam logic [2:0] S_MLO  = 3'd3;
  localparam logic [2:0] S_MHI  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_NORM = 3'd7;

  logic [2:0]  state;
  logic [8:0]  smoothing_weight;
  logic [15:0] impact_threshold;
  logic [31:0] holdoff_time;
  logic [tid_pkg::TIME_BITS-1:0] last_accel_time, last_gyro_time, last_impact_time;
  logic [tid_pkg::TIME_BITS-1:0] item_ts, dt;
  logic                          item_op;
  logic signed [tid_pkg::SAMPLE_BITS-1:0] item_s [3];
  logic [31:0]                   thr2;

  tid_pkg::lane_ctrl_t ctrl;
  logic [8:0]          w_eff;
  logic signed [tid_pkg::LIN_W-1:0]  lin [3];
  logic [tid_pkg::SQ_W-1:0]          lin_sq [3];
  logic signed [tid_pkg::INT_W-1:0]  acc_vec [3];
  logic signed [tid_pkg::INT_W-1:0]  rot_vec [3];
  logic signed [tid_pkg::DIR_W-1:0]  acc_dir [3];
  logic signed [tid_pkg::DIR_W-1:0]  rot_dir [3];
  logic acc_busy, rot_busy;
  logic [tid_pkg::SQ_W+1:0]      mag2;
  logic [tid_pkg::TIME_BITS-1:0] since;
  logic fire, load_out;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // weight above 256 acts as 256
  assign w_eff = (smoothing_weight[8] && smoothing_weight[7:0] != '0) ? 9'd256
                                                                       : smoothing_weight;

  // lane strobes
  always_comb begin
    ctrl.grav_en = (state == S_GRAV);
    ctrl.lin_en  = (state == S_LIN);
    ctrl.mul_lo  = (state == S_MLO);
    ctrl.mul_hi  = (state == S_MHI);
    ctrl.acc_en  = (state == S_ACC);
    ctrl.gyro    = item_op;
    ctrl.clear   = fire;
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    tid_lane u_lane (
      .clk(clk), .rst(rst), .ctrl(ctrl), .weight(w_eff), .sample(item_s[i]), .dt(dt),
      .lin(lin[i]), .lin_sq(lin_sq[i]), .accel_int(acc_vec[i]), .rate_int(rot_vec[i])
    );
  end

  tid_norm u_acc_norm (
    .clk(clk), .rst(rst), .start(fire), .vec(acc_vec), .busy(acc_busy), .dir(acc_dir)
  );
  tid_norm u_rot_norm (
    .clk(clk), .rst(rst), .start(fire), .vec(rot_vec), .busy(rot_busy), .dir(rot_dir)
  );

  // merge: magnitude test, sign test, hold-off
  always_comb begin
    mag2  = (tid_pkg::SQ_W+2)'(lin_sq[0]) + (tid_pkg::SQ_W+2)'(lin_sq[1])
          + (tid_pkg::SQ_W+2)'(lin_sq[2]);
    since = item_ts - last_impact_time;
    fire  = (state == S_CHK) && (mag2 > (tid_pkg::SQ_W+2)'(thr2))
          && !lin[0][tid_pkg::LIN_W-1] && (lin[0] != '0)
          && (68'(since) >= 68'(holdoff_time));
    load_out = (state == S_NORM) && !acc_busy && !rot_busy && (!out_valid || out_ready);
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      smoothing_weight <= 9'd205;
      impact_threshold <= 16'd1434;
      holdoff_time     <= 32'd200000;
      last_accel_time  <= '0;
      last_gyro_time   <= '0;
      last_impact_time <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tid_pkg::REG_WEIGHT:  smoothing_weight <= cfg_data[8:0];
          tid_pkg::REG_THRESH:  impact_threshold <= cfg_data[15:0];
          tid_pkg::REG_HOLDOFF: holdoff_time     <= cfg_data;
          default:              smoothing_weight <= smoothing_weight;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_GRAV;
            if (op) last_gyro_time <= timestamp;
            else    last_accel_time <= timestamp;
          end
        end
        S_GRAV:  state <= S_LIN;
        S_LIN:   state <= S_MLO;
        S_MLO:   state <= S_MHI;
        S_MHI:   state <= S_ACC;
        S_ACC:   state <= item_op ? S_IDLE : S_CHK;
        S_CHK: begin
          if (fire) begin
            state            <= S_NORM;
            last_impact_time <= item_ts;
          end else begin
            state <= S_IDLE;
          end
        end
        S_NORM:  if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      item_op   <= op;
      item_ts   <= timestamp;
      item_s[0] <= sample_x;
      item_s[1] <= sample_y;
      item_s[2] <= sample_z;
      dt        <= timestamp - (op ? last_gyro_time : last_accel_time);
    end
    if (state == S_GRAV) begin
      thr2 <= impact_threshold * impact_threshold;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      impact_time <= 48'(item_ts);
      linear_x    <= 17'(lin[0]);
      linear_y    <= 17'(lin[1]);
      linear_z    <= 17'(lin[2]);
      accel_dir_x <= acc_dir[0];
      accel_dir_y <= acc_dir[1];
      accel_dir_z <= acc_dir[2];
      rot_dir_x   <= rot_dir[0];
      rot_dir_y   <= rot_dir[1];
      rot_dir_z   <= rot_dir[2];
    end
  end

  `TID_ASSERT_RST(a_reset_idle, clk, rst |=> state == S_IDLE && !out_valid)
  `TID_ASSERT(a_accept_start, clk, rst, in_valid && in_ready |=> state == S_GRAV)
  `TID_ASSERT(a_idle_quiet, clk, rst, state == S_IDLE |-> !acc_busy && !rot_busy)
  `TID_ASSERT(a_gyro_silent, clk, rst, state == S_ACC && item_op |=> state == S_IDLE)

endmodule

/* tb/sv/tap_impact_detector_tb.sv */
// Self-checking testbench for tap_impact_detector: directed and random timed samples.
// A built-in predictor checks every impact result. Depends on tid_pkg and the RTL top level.
module tap_impact_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN64 = 64'sh8000_0000_0000_0000;
  localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 150;

  typedef struct {
    logic        gyro;
    logic [47:0] ts;
    logic signed [15:0] x, y, z;
  } sample_t;

  typedef struct {
    longint f[10];
  } impact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic op = 1'b0;
  logic [47:0] timestamp = '0;
  logic signed [15:0] sample_x = '0, sample_y = '0, sample_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic [47:0] impact_time;
  logic signed [16:0] linear_x, linear_y, linear_z;
  logic signed [15:0] accel_dir_x, accel_dir_y, accel_dir_z;
  logic signed [15:0] rot_dir_x, rot_dir_y, rot_dir_z;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = tid_pkg::REG_WEIGHT;
  logic [31:0] cfg_data = '0;

  sample_t sample_q[$];
  impact_t impact_q[$];
  sample_t next_sample;
  int fail_count = 0;
  int send_gap = 0, recv_gap = 0, idle_cycles = 0;
  bit quiet = 1'b0;
  logic [47:0] ts_now = '0;

  // predictor state and configuration
  longint unsigned weight_r, thresh_r, holdoff_r;
  longint grav[3], acc_int[3], rate_int[3];
  logic [47:0] last_acc_t, last_gyro_t, last_hit_t;

  tap_impact_detector i_dut (.*);

  always #6 clk = ~clk;

  function automatic longint sat_sum(longint a, longint b);
    if (b > 0 && a > MAX64 - b) return MAX64;
    if (b < 0 && a < MIN64 - b) return MIN64;
    return a + b;
  endfunction

  function automatic longint sat_prod(longint unsigned dt, longint v);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    if (mag == 0 || dt == 0) return 0;
    if (dt > longint'(MAX64) / mag) return (v < 0) ? MIN64 : MAX64;
    return (v < 0) ? -longint'(dt * mag) : longint'(dt * mag);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector in Q1.14, magnitudes pre-shifted below 2^31
  function automatic void unit_vec(input longint v[3], output longint d[3]);
    longint unsigned mag[3], mx, s, m, t;
    longint c[3];
    int k;
    mx = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? (64'd0 - longint'(v[i])) : longint'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> k) >= (64'd1 << 31)) k++;
    for (int i = 0; i < 3; i++) begin
      t = mag[i] >> k;
      c[i] = (v[i] < 0) ? -longint'(t) : longint'(t);
      s += t * t;
    end
    m = int_sqrt(s);
    for (int i = 0; i < 3; i++) d[i] = (m == 0) ? 0 : (c[i] * 16384) / longint'(m);
  endfunction

  task automatic predict_impact(input sample_t smp);
    longint s[3], lin[3], ad[3], rd[3], w;
    longint unsigned dt, mag2;
    impact_t r;
    s[0] = smp.x;
    s[1] = smp.y;
    s[2] = smp.z;
    if (smp.gyro) begin
      dt = (smp.ts - last_gyro_t) & TMASK;
      last_gyro_t = smp.ts;
      for (int i = 0; i < 3; i++) rate_int[i] = sat_sum(rate_int[i], sat_prod(dt, s[i]));
      return;
    end
    w = (weight_r > 256) ? 256 : longint'(weight_r);
    dt = (smp.ts - last_acc_t) & TMASK;
    last_acc_t = smp.ts;
    mag2 = 0;
    for (int i = 0; i < 3; i++) begin
      grav[i] = (w * grav[i] + (256 - w) * s[i] * 256) >>> 8;
      lin[i] = s[i] - (grav[i] >>> 8);
      acc_int[i] = sat_sum(acc_int[i], sat_prod(dt, lin[i]));
      mag2 += longint'(lin[i] * lin[i]);
    end
    if (!(mag2 > thresh_r * thresh_r && lin[0] > 0)) return;
    if (((smp.ts - last_hit_t) & TMASK) < holdoff_r) return;
    last_hit_t = smp.ts;
    unit_vec(acc_int, ad);
    unit_vec(rate_int, rd);
    for (int i = 0; i < 3; i++) begin
      acc_int[i] = 0;
      rate_int[i] = 0;
    end
    r.f[0] = smp.ts;
    for (int i = 0; i < 3; i++) begin
      r.f[1 + i] = lin[i];
      r.f[4 + i] = ad[i];
      r.f[7 + i] = rd[i];
    end
    impact_q.push_back(r);
  endtask

  // request driver; predicts on every accepted sample
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_impact('{op, timestamp, sample_x, sample_y, sample_z});
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (sample_q.size() > 0) begin
          next_sample = sample_q.pop_front();
          in_valid <= 1'b1;
          op <= next_sample.gyro;
          timestamp <= next_sample.ts;
          sample_x <= next_sample.x;
          sample_y <= next_sample.y;
          sample_z <= next_sample.z;
          if (!quiet && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    logic signed [63:0] got[10];
    impact_t exp_r;
    bit bad;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{impact_time, linear_x, linear_y, linear_z, accel_dir_x, accel_dir_y,
                accel_dir_z, rot_dir_x, rot_dir_y, rot_dir_z};
        if (impact_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("expected no impact, got impact at time %0d", impact_time);
        end else begin
          exp_r = impact_q.pop_front();
          bad = 1'b0;
          for (int i = 0; i < 10; i++) begin
            if (got[i] != exp_r.f[i]) begin
              bad = 1'b1;
              if (fail_count < 10)
                $display("impact field %0d: expected %0d, got %0d", i, exp_r.f[i], got[i]);
            end
          end
          if (bad) fail_count++;
        end
      end
      if (recv_gap != 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) recv_gap <= $urandom_range(1, 3);
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tid_pkg::REG_WEIGHT:  weight_r = val & 32'h1FF;
      tid_pkg::REG_THRESH:  thresh_r = val & 32'hFFFF;
      tid_pkg::REG_HOLDOFF: holdoff_r = val;
      default: ;
    endcase
  endtask

  // let every pending request finish, then wait out unreported work
  task automatic drain();
    while (sample_q.size() > 0 || in_valid || send_gap != 0 || impact_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int w, input int t, input logic [31:0] h);
    drain();
    write_reg(tid_pkg::REG_WEIGHT, w);
    write_reg(tid_pkg::REG_THRESH, t);
    write_reg(tid_pkg::REG_HOLDOFF, h);
  endtask

  task automatic add(input bit g, input logic [47:0] ts, input int x, input int y, input int z);
    sample_q.push_back('{g, ts, 16'(x), 16'(y), 16'(z)});
  endtask

  // mostly resting readings around 1 g on z, with taps and some noise
  task automatic add_random(input int n);
    int x, y, z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0:       ts_now = 48'({$urandom(), $urandom()});
        1:       ts_now = 48'(ts_now + {$urandom(), $urandom()});
        default: ts_now = ts_now + $urandom_range(1, 30000);
      endcase
      x = $signed(16'($urandom_range(0, 400))) - 200;
      y = $signed(16'($urandom_range(0, 400))) - 200;
      z = 2048 + $signed(16'($urandom_range(0, 400))) - 200;
      case ($urandom_range(0, 9))
        0, 1: x = $urandom_range(3000, 32767);
        2: begin
          x = $signed(16'($urandom()));
          y = $signed(16'($urandom()));
          z = $signed(16'($urandom()));
        end
        default: ;
      endcase
      add($urandom_range(0, 2) == 0, ts_now, x, y, z);
    end
  endtask

  initial begin
    weight_r = 205;
    thresh_r = 1434;
    holdoff_r = 200000;
    for (int i = 0; i < 3; i++) begin
      grav[i] = 0;
      acc_int[i] = 0;
      rate_int[i] = 0;
    end
    last_acc_t = '0;
    last_gyro_t = '0;
    last_hit_t = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: early impact held off, then a real one
    add(0, 48'd0, 32767, 0, 2048);
    add(1, 48'd100, -32768, -32768, -32768);
    add(1, 48'd150, 32767, 32767, 32767);
    add(0, 48'd300000, 32767, -32768, 0);
    add(0, 48'd300000, 32767, 32767, 0);
    add(0, 48'd350000, -32768, 0, 2048);

    // no hold-off, gravity frozen: back-to-back impacts with zero integrals
    set_config(256, 0, 0);
    add(0, 48'd400000, 20000, 0, 0);
    add(0, 48'd400000, 20000, 0, 0);
    add(0, 48'd400001, 0, 0, 0);

    // no smoothing: extreme samples with zero linear values, large rate integrals, time wrap
    set_config(0, 0, 0);
    add(0, 48'd500000, -32768, -32768, -32768);
    add(1, 48'hFFFF_FFFF_FFF0, -32768, 32767, 0);
    add(1, 48'hFFFF_FFFF_FFF0, 0, 0, 0);
    add(0, 48'hFFFF_FFFF_FFF0, 32767, 32767, 32767);
    add(0, 48'd5, 32767, 0, 0);
    ts_now = 48'd10;

    // random phases over several settings; hold-off extremes included
    set_config(205, 1434, 20000);
    add_random(350);
    set_config(511, 65535, 32'hFFFF_FFFF);
    add_random(150);
    set_config(128, 1000, 0);
    add_random(350);
    set_config($urandom_range(0, 511), $urandom_range(500, 4000), $urandom_range(0, 60000));
    add_random(350);
    set_config($urandom_range(0, 256), $urandom_range(0, 3000), $urandom_range(0, 100000));
    quiet = 1'b1;
    add_random(550);
    drain();

    if (fail_count == 0 && impact_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* tap_impact_detector.f */
+incdir+rtl
rtl/tid_pkg.sv
rtl/tid_lane.sv
rtl/tid_norm.sv
rtl/tap_impact_detector.sv
tb/sv/tap_impact_detector_tb.sv
